[sv/kslt_pkg.sv]
package kslt_pkg;

	localparam int K_ENTRIES_DEF  = 32;
	localparam int INDEX_BITS_DEF = 20;
	localparam int KEY_BITS       = 32;
	localparam int OP_BITS        = 2;

	// Operation codes of an input transfer. The fourth code is unused.
	typedef enum logic [OP_BITS-1:0] {
		OP_CLEAR = 2'd0,
		OP_LOAD  = 2'd1,
		OP_OFFER = 2'd2
	} op_t;

	// Source of the address on the first key read port.
	typedef enum logic [1:0] {
		KS_BUILD  = 2'd0,
		KS_REPLAY = 2'd1,
		KS_HEAD   = 2'd2
	} key_sel_t;

	typedef struct packed {
		logic     clear;
		logic     load;
		logic     offer;
		logic     reject;
		logic     bld_step;
		logic     rp_step;
		logic     head_cap;
		logic     out_load;
		key_sel_t ksel;
	} dp_cmd_t;

	typedef struct packed {
		logic full;
		logic last_load;
		logic offer_ok;
		logic node_one;
	} dp_stat_t;

endpackage

[sv/k_smallest_loser_tree.sv]
// Channel   Handshake                  Payload
// item      item_valid / item_stall    operation, key, item_index
// result    result_valid / result_stall head_key, head_index, tree_ready, accepted
//
// Every item transfer yields exactly one result transfer. Clear, rejected items
// and the unused operation code go straight to the response state, as does a
// load that does not fill the store. The load that fills the store builds the
// tree over the K-1 internal nodes, each step reading the child winners, then
// both keys, then comparing; it then reads and captures the new head and
// presents it before returning to idle. An accepted offer replays up the tree
// over the levels above the head leaf (five levels for K of 32), each step
// reading the node's loser, then its key, then comparing. The read-registered
// ports of the node and key memories set the steps of both walks.
// Reset (arst_n low) empties the store and drops any pending result. A stalled
// result holds in the output register; the next item is not taken until the
// current one has reached that register.
module k_smallest_loser_tree #(
	parameter int K_ENTRIES  = kslt_pkg::K_ENTRIES_DEF,
	parameter int INDEX_BITS = kslt_pkg::INDEX_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [kslt_pkg::OP_BITS-1:0]  operation,
	input  logic [kslt_pkg::KEY_BITS-1:0] key,
	input  logic [INDEX_BITS-1:0]         item_index,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [kslt_pkg::KEY_BITS-1:0] head_key,
	output logic [INDEX_BITS-1:0]         head_index,
	output logic                          tree_ready,
	output logic                          accepted
);

	// The controller sequences the build and replay walks; the datapath owns
	// the leaf, loser and winner memories together with the head registers.
	kslt_pkg::dp_cmd_t  cmd;
	kslt_pkg::dp_stat_t stat;

	kslt_controller u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.operation    (operation),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.stat         (stat),
		.cmd          (cmd)
	);

	kslt_datapath #(
		.K_ENTRIES  (K_ENTRIES),
		.INDEX_BITS (INDEX_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.key        (key),
		.item_index (item_index),
		.head_key   (head_key),
		.head_index (head_index),
		.tree_ready (tree_ready),
		.accepted   (accepted)
	);

endmodule

[sv/kslt_datapath.sv]
module kslt_datapath #(
	parameter int K_ENTRIES  = kslt_pkg::K_ENTRIES_DEF,
	parameter int INDEX_BITS = kslt_pkg::INDEX_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  kslt_pkg::dp_cmd_t             cmd,
	output kslt_pkg::dp_stat_t            stat,
	input  logic [kslt_pkg::KEY_BITS-1:0] key,
	input  logic [INDEX_BITS-1:0]         item_index,
	output logic [kslt_pkg::KEY_BITS-1:0] head_key,
	output logic [INDEX_BITS-1:0]         head_index,
	output logic                          tree_ready,
	output logic                          accepted
);

	localparam int LW = $clog2(K_ENTRIES);
	localparam int CW = $clog2(K_ENTRIES + 1);
	localparam int KB = kslt_pkg::KEY_BITS;
	localparam logic [LW:0]   K_EXT     = (LW+1)'(K_ENTRIES);
	localparam logic [LW-1:0] LAST_NODE = LW'(K_ENTRIES - 1);
	localparam logic [CW-1:0] K_CNT     = CW'(K_ENTRIES);
	localparam logic [CW-1:0] LAST_CNT  = CW'(K_ENTRIES - 1);

	logic [KB-1:0]         keys_mem   [K_ENTRIES];
	logic [INDEX_BITS-1:0] idx_mem    [K_ENTRIES];
	logic [LW-1:0]         loser_mem  [K_ENTRIES];
	logic [LW-1:0]         winner_mem [K_ENTRIES];

	logic [CW-1:0]         count_q;
	logic [LW-1:0]         head_leaf_q;
	logic [LW-1:0]         node_q;
	logic [LW-1:0]         hand_q;
	logic [KB-1:0]         hand_key_q;
	logic [KB-1:0]         head_key_q;
	logic [INDEX_BITS-1:0] head_idx_q;
	logic                  acc_q;

	logic [LW-1:0]         win_a_q;
	logic [LW-1:0]         win_b_q;
	logic [LW-1:0]         los_q;
	logic [KB-1:0]         key_a_q;
	logic [KB-1:0]         key_b_q;
	logic [INDEX_BITS-1:0] idx_rd_q;

	logic [KB-1:0]         out_key_q;
	logic [INDEX_BITS-1:0] out_idx_q;
	logic                  out_ready_q;
	logic                  out_acc_q;

	logic [LW:0]   child_a;
	logic [LW:0]   child_b;
	logic [LW:0]   head_sum;
	logic [LW-1:0] left_leaf;
	logic [LW-1:0] right_leaf;
	logic [LW-1:0] key_a_addr;
	logic [LW-1:0] wr_addr;
	logic [LW-1:0] loser_sel;
	logic [LW-1:0] winner_sel;
	logic [LW-1:0] new_hand;
	logic          full;
	logic          swap;

	assign child_a  = {node_q, 1'b0};
	assign child_b  = {node_q, 1'b1};
	assign head_sum = (LW+1)'(head_leaf_q) + K_EXT;

	// A child number at or above K names a leaf directly.
	assign left_leaf  = (child_a < K_EXT) ? win_a_q : LW'(child_a - K_EXT);
	assign right_leaf = (child_b < K_EXT) ? win_b_q : LW'(child_b - K_EXT);

	always_comb begin
		case (cmd.ksel)
			kslt_pkg::KS_BUILD:  key_a_addr = left_leaf;
			kslt_pkg::KS_REPLAY: key_a_addr = los_q;
			default:             key_a_addr = head_leaf_q;
		endcase
	end

	assign wr_addr = cmd.load ? count_q[LW-1:0] : head_leaf_q;

	// On a tie the left entry wins the build match.
	assign loser_sel  = (key_a_q < key_b_q) ? left_leaf : right_leaf;
	assign winner_sel = (key_a_q < key_b_q) ? right_leaf : left_leaf;

	assign swap     = key_a_q > hand_key_q;
	assign new_hand = swap ? los_q : hand_q;

	assign full = count_q == K_CNT;

	assign stat.full      = full;
	assign stat.last_load = count_q == LAST_CNT;
	assign stat.offer_ok  = full && (key < head_key_q);
	assign stat.node_one  = node_q == LW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			head_leaf_q <= '0;
		end else if (cmd.clear) begin
			count_q     <= '0;
			head_leaf_q <= '0;
		end else if (cmd.load) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.bld_step && stat.node_one) begin
			head_leaf_q <= winner_sel;
		end else if (cmd.rp_step && stat.node_one) begin
			head_leaf_q <= new_hand;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load || cmd.offer) begin
			keys_mem[wr_addr] <= key;
			idx_mem[wr_addr]  <= item_index;
		end
		if (cmd.bld_step) begin
			loser_mem[node_q]  <= loser_sel;
			winner_mem[node_q] <= winner_sel;
		end else if (cmd.rp_step && swap) begin
			loser_mem[node_q] <= hand_q;
		end

		win_a_q  <= winner_mem[child_a[LW-1:0]];
		win_b_q  <= winner_mem[child_b[LW-1:0]];
		los_q    <= loser_mem[node_q];
		key_a_q  <= keys_mem[key_a_addr];
		key_b_q  <= keys_mem[right_leaf];
		idx_rd_q <= idx_mem[head_leaf_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			node_q <= LAST_NODE;
			acc_q  <= 1'b1;
		end else if (cmd.offer) begin
			hand_q     <= head_leaf_q;
			hand_key_q <= key;
			node_q     <= head_sum[LW:1];
			acc_q      <= 1'b1;
		end else if (cmd.clear || cmd.reject) begin
			acc_q <= 1'b0;
		end else if (cmd.bld_step) begin
			node_q <= node_q - LW'(1);
		end else if (cmd.rp_step) begin
			node_q     <= node_q >> 1;
			hand_q     <= new_hand;
			hand_key_q <= swap ? key_a_q : hand_key_q;
		end

		if (cmd.head_cap) begin
			head_key_q <= key_a_q;
			head_idx_q <= idx_rd_q;
		end

		if (cmd.out_load) begin
			out_key_q   <= full ? head_key_q : '0;
			out_idx_q   <= full ? head_idx_q : '0;
			out_ready_q <= full;
			out_acc_q   <= acc_q;
		end
	end

	assign head_key   = out_key_q;
	assign head_index = out_idx_q;
	assign tree_ready = out_ready_q;
	assign accepted   = out_acc_q;

endmodule

[sv/kslt_controller.sv]
module kslt_controller (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic [kslt_pkg::OP_BITS-1:0] operation,
	output logic                         result_valid,
	input  logic                         result_stall,
	input  kslt_pkg::dp_stat_t           stat,
	output kslt_pkg::dp_cmd_t            cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BLD_RW,
		ST_BLD_RK,
		ST_BLD_CMP,
		ST_RP_RL,
		ST_RP_RK,
		ST_RP_CMP,
		ST_HD_RD,
		ST_HD_CAP,
		ST_RESP
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   result_valid_q;

	always_comb begin
		cmd      = '0;
		cmd.ksel = kslt_pkg::KS_HEAD;
		state_d  = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					state_d = ST_RESP;
					case (kslt_pkg::op_t'(operation))
						kslt_pkg::OP_CLEAR: begin
							cmd.clear = 1'b1;
						end
						kslt_pkg::OP_LOAD: begin
							if (!stat.full) begin
								cmd.load = 1'b1;
								if (stat.last_load) begin
									state_d = ST_BLD_RW;
								end
							end else begin
								cmd.reject = 1'b1;
							end
						end
						kslt_pkg::OP_OFFER: begin
							if (stat.offer_ok) begin
								cmd.offer = 1'b1;
								state_d   = ST_RP_RL;
							end else begin
								cmd.reject = 1'b1;
							end
						end
						default: begin
							cmd.reject = 1'b1;
						end
					endcase
				end
			end
			ST_BLD_RW: begin
				state_d = ST_BLD_RK;
			end
			ST_BLD_RK: begin
				cmd.ksel = kslt_pkg::KS_BUILD;
				state_d  = ST_BLD_CMP;
			end
			ST_BLD_CMP: begin
				cmd.bld_step = 1'b1;
				state_d      = stat.node_one ? ST_HD_RD : ST_BLD_RW;
			end
			ST_RP_RL: begin
				state_d = ST_RP_RK;
			end
			ST_RP_RK: begin
				cmd.ksel = kslt_pkg::KS_REPLAY;
				state_d  = ST_RP_CMP;
			end
			ST_RP_CMP: begin
				cmd.rp_step = 1'b1;
				state_d     = stat.node_one ? ST_HD_RD : ST_RP_RL;
			end
			ST_HD_RD: begin
				state_d = ST_HD_CAP;
			end
			ST_HD_CAP: begin
				cmd.head_cap = 1'b1;
				state_d      = ST_RESP;
			end
			ST_RESP: begin
				if (!result_valid_q || !result_stall) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign item_stall   = state_q != ST_IDLE;
	assign result_valid = result_valid_q;

endmodule
